// ----- sv/mi4_pkg.sv -----
package mi4_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IDX_W     = 4;
   localparam int ELEM_W    = 32;
   localparam int WIDE_W    = 64;
   localparam int MAG_W     = 63;
   localparam int THR_W     = 31;
   localparam int DEPTH     = 16;

   localparam logic [THR_W-1:0]  THR_RESET = 31'd7;
   localparam logic [WIDE_W-1:0] SMAX      = 64'h7FFF_FFFF_FFFF_FFFF;

endpackage

// ----- sv/mi4_if.sv -----
interface mi4_req_if import mi4_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         element_index;
   logic signed [ELEM_W-1:0] element_value;
   modport source (output valid, element_index, element_value, input ready);
   modport sink (input valid, element_index, element_value, output ready);
endinterface

interface mi4_rsp_if import mi4_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         out_index;
   logic signed [ELEM_W-1:0] out_value;
   logic                     singular;
   logic                     saturated;
   logic                     last;
   modport source (output valid, out_index, out_value, singular, saturated, last,
                   input ready);
   modport sink (input valid, out_index, out_value, singular, saturated, last,
                 output ready);
endinterface

interface mi4_csr_if import mi4_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [THR_W-1:0] det_threshold;
   modport source (output valid, det_threshold, input ready);
   modport sink (input valid, det_threshold, output ready);
endinterface

// ----- sv/mi4_ram.sv -----
module mi4_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/mi4_mul.sv -----
module mi4_mul import mi4_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              shift_hi,
   input  logic [WIDE_W-1:0] a,
   input  logic [WIDE_W-1:0] b,
   output logic              done,
   output logic [MAG_W-1:0]  result
);

   localparam int SH_LO = FRAC_BITS;
   localparam int SH_HI = 63 - FRAC_BITS;

   logic [WIDE_W-1:0]   a_ff, b_ff;
   logic [WIDE_W-1:0]   pp_ff;
   logic [1:0]          off_ff;
   logic [2*WIDE_W-1:0] acc_ff;
   logic [2:0]          cnt_ff;
   logic                busy_ff, done_ff, hi_ff;
   logic [31:0]         op_a, op_b;
   logic [2*WIDE_W-1:0] pp_ext;

   always_comb begin
      op_a = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
      op_b = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
      case (off_ff)
         2'd0:    pp_ext = {64'd0, pp_ff};
         2'd1:    pp_ext = {32'd0, pp_ff, 32'd0};
         default: pp_ext = {pp_ff, 64'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            a_ff    <= a;
            b_ff    <= b;
            hi_ff   <= shift_hi;
            acc_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff != 3'd4) begin
               pp_ff  <= op_a * op_b;
               off_ff <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
            end
            if (cnt_ff != 3'd0) begin
               acc_ff <= acc_ff + pp_ext;
            end
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 3'd1;
         end
      end
   end

   always_comb begin
      if (hi_ff) begin
         result = (|acc_ff[127:SH_HI+63]) ? SMAX[MAG_W-1:0] : acc_ff[SH_HI+62:SH_HI];
      end else begin
         result = (|acc_ff[127:SH_LO+63]) ? SMAX[MAG_W-1:0] : acc_ff[SH_LO+62:SH_LO];
      end
   end

   assign done = done_ff;

endmodule

// ----- sv/mi4_div.sv -----
module mi4_div import mi4_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  divisor,
   output logic              done,
   output logic [WIDE_W-1:0] quotient
);

   logic [MAG_W-1:0]  d_ff, rem_ff;
   logic [WIDE_W-1:0] q_ff;
   logic [5:0]        cnt_ff;
   logic              busy_ff, done_ff;
   logic [WIDE_W-1:0] shifted, diff;
   logic              take;

   always_comb begin
      shifted = {rem_ff, (cnt_ff == 6'd0)};
      take    = shifted >= {1'b0, d_ff};
      diff    = shifted - {1'b0, d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            d_ff    <= divisor;
            rem_ff  <= '0;
            q_ff    <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= take ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            q_ff   <= {q_ff[WIDE_W-2:0], take};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ----- sv/matrix_inverse_4x4_unit.sv -----
// Inverts a 4x4 signed Q16.16 matrix by cofactors. Elements arrive on the req channel, one
// transaction per element, addressed column-major (col*4+row); each is stored as it is accepted.
// A transaction with index 15 starts an inversion of the stored matrix, during which req is
// not ready. The block then delivers 16 transactions on the rsp channel, index 0 to 15, with
// last set on the sixteenth. The csr channel writes the singularity threshold and is always
// ready; it should be written only while no inversion is running.
// All multiplication passes through one shared 64x64 multiplier that takes one 32x32 partial
// product a cycle. Each of the 96 triple products of the cofactors takes three element reads
// and two products, the determinant four products, the reciprocal a run of a bit-serial
// divider, and each result one more product.
// When a result waits because the receiver is not ready, the sequencer holds until the
// output register is free; the next matrix may be loaded while the last result waits.
// Reset clears the control state and sets the threshold to 7; both stores are undefined
// until written.
module matrix_inverse_4x4_unit import mi4_pkg::*; (
   input  logic clock,
   input  logic reset,
   mi4_req_if.sink   req_bus,
   mi4_rsp_if.source rsp_bus,
   mi4_csr_if.sink   csr_bus
);

   typedef enum logic [4:0] {
      S_IDLE, M_RD0, M_RD1, M_RD2, M_RD3, M_W1, M_W2,
      D_RD, D_CAP, D_W, D_FIN, V_W, E_RD, E_CAP, E_W, E_OUT
   } state_type;

   state_type                state_ff;
   logic [IDX_W-1:0]         k_ff;
   logic [2:0]               t_ff;
   logic signed [ELEM_W-1:0] x_ff, y_ff, z_ff;
   logic signed [WIDE_W-1:0] acc_ff;
   logic                     neg_ff, det_neg_ff, sing_ff;
   logic [WIDE_W-1:0]        recip_ff;
   logic [THR_W-1:0]         thr_ff;
   logic signed [ELEM_W-1:0] res_val_ff;
   logic                     res_sat_ff;

   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic signed [ELEM_W-1:0] rsp_value_ff;
   logic                     rsp_sing_ff, rsp_sat_ff, rsp_last_ff;

   logic                     mat_we, mat_re, cof_we, cof_re;
   logic [IDX_W-1:0]         mat_raddr, cof_raddr;
   logic [ELEM_W-1:0]        mat_rdata;
   logic [WIDE_W-1:0]        cof_rdata, cof_wdata;

   logic                     mul_start, mul_hi, mul_done;
   logic [WIDE_W-1:0]        mul_a, mul_b;
   logic [MAG_W-1:0]         mul_res;
   logic                     div_start, div_done;
   logic [WIDE_W-1:0]        div_q;

   logic signed [WIDE_W-1:0] term, sum, cof_val, mat_ext, det_sum;
   logic [WIDE_W-1:0]        dmag;
   logic                     sing_now, slot_free;

   function automatic logic [WIDE_W-1:0] mag64(input logic signed [WIDE_W-1:0] v);
      return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
   endfunction

   function automatic logic signed [WIDE_W-1:0] sat_add(input logic signed [WIDE_W-1:0] a,
                                                        input logic signed [WIDE_W-1:0] b);
      logic signed [WIDE_W:0] s;
      s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
      if (s > $signed({1'b0, SMAX})) begin
         return $signed(SMAX);
      end else if (s < -$signed({1'b0, SMAX})) begin
         return -$signed(SMAX);
      end
      return s[WIDE_W-1:0];
   endfunction

   function automatic logic [3:0] term_pos(input logic [2:0] t, input logic [1:0] p);
      logic [11:0] row_set;
      case (t)
         3'd0:    row_set = {4'h0, 4'h5, 4'hA};
         3'd1:    row_set = {4'h1, 4'h6, 4'h8};
         3'd2:    row_set = {4'h2, 4'h4, 4'h9};
         3'd3:    row_set = {4'h2, 4'h5, 4'h8};
         3'd4:    row_set = {4'h0, 4'h6, 4'h9};
         default: row_set = {4'h1, 4'h4, 4'hA};
      endcase
      case (p)
         2'd0:    return row_set[11:8];
         2'd1:    return row_set[7:4];
         default: return row_set[3:0];
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] elem_addr(input logic [IDX_W-1:0] k,
                                                  input logic [2:0] t, input logic [1:0] p);
      logic [3:0] pos;
      logic [1:0] r, c;
      pos = term_pos(t, p);
      r   = (pos[3:2] >= k[3:2]) ? pos[3:2] + 2'd1 : pos[3:2];
      c   = (pos[1:0] >= k[1:0]) ? pos[1:0] + 2'd1 : pos[1:0];
      return {c, r};
   endfunction

   mi4_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_mat (
      .clock(clock), .wr_en(mat_we), .wr_addr(req_bus.element_index),
      .wr_data(req_bus.element_value), .rd_en(mat_re), .rd_addr(mat_raddr),
      .rd_data(mat_rdata)
   );

   mi4_ram #(.WIDTH(WIDE_W), .DEPTH(DEPTH)) u_cof (
      .clock(clock), .wr_en(cof_we), .wr_addr(k_ff), .wr_data(cof_wdata),
      .rd_en(cof_re), .rd_addr(cof_raddr), .rd_data(cof_rdata)
   );

   mi4_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .shift_hi(mul_hi),
      .a(mul_a), .b(mul_b), .done(mul_done), .result(mul_res)
   );

   mi4_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .divisor(dmag[MAG_W-1:0]),
      .done(div_done), .quotient(div_q)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      mat_we    = req_bus.valid && (state_ff == S_IDLE);
      mat_re    = 1'b0;
      mat_raddr = elem_addr(k_ff, t_ff, 2'd0);
      cof_re    = 1'b0;
      cof_raddr = k_ff;
      mul_start = 1'b0;
      mul_hi    = 1'b0;
      mul_a     = mag64(WIDE_W'(x_ff));
      mul_b     = mag64(WIDE_W'(y_ff));
      mat_ext   = WIDE_W'(signed'(mat_rdata));
      case (state_ff)
         M_RD0: begin
            mat_re = 1'b1;
         end
         M_RD1: begin
            mat_re    = 1'b1;
            mat_raddr = elem_addr(k_ff, t_ff, 2'd1);
         end
         M_RD2: begin
            mat_re    = 1'b1;
            mat_raddr = elem_addr(k_ff, t_ff, 2'd2);
         end
         M_RD3: begin
            mul_start = 1'b1;
         end
         M_W1: begin
            mul_start = mul_done;
            mul_a     = {1'b0, mul_res};
            mul_b     = mag64(WIDE_W'(z_ff));
         end
         D_RD: begin
            mat_re    = 1'b1;
            mat_raddr = {2'd0, k_ff[1:0]};
            cof_re    = 1'b1;
            cof_raddr = {k_ff[1:0], 2'd0};
         end
         D_CAP: begin
            mul_start = 1'b1;
            mul_a     = mag64(mat_ext);
            mul_b     = mag64(cof_rdata);
         end
         E_RD: begin
            cof_re = 1'b1;
         end
         E_CAP: begin
            mul_start = !sing_ff;
            mul_hi    = 1'b1;
            mul_a     = mag64(cof_rdata);
            mul_b     = recip_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      term      = (neg_ff ^ (t_ff >= 3'd3)) ? -$signed({1'b0, mul_res})
                                             : $signed({1'b0, mul_res});
      sum       = sat_add(acc_ff, term);
      cof_val   = (k_ff[2] ^ k_ff[0]) ? -sum : sum;
      cof_wdata = cof_val;
      cof_we    = (state_ff == M_W2) && mul_done && (t_ff == 3'd5);
      det_sum   = sat_add(acc_ff, neg_ff ? -$signed({1'b0, mul_res})
                                         : $signed({1'b0, mul_res}));
      dmag      = mag64(acc_ff);
      sing_now  = (dmag == '0) || (dmag < {33'd0, thr_ff});
      div_start = (state_ff == D_FIN) && !sing_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         t_ff         <= '0;
      end else begin
         if (csr_bus.valid) begin
            thr_ff <= csr_bus.det_threshold;
         end
         if (rsp_bus.ready && (state_ff != E_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_bus.valid && (req_bus.element_index == 4'd15)) begin
                  k_ff     <= '0;
                  t_ff     <= '0;
                  acc_ff   <= '0;
                  state_ff <= M_RD0;
               end
            end
            M_RD0: state_ff <= M_RD1;
            M_RD1: begin
               x_ff     <= mat_rdata;
               state_ff <= M_RD2;
            end
            M_RD2: begin
               y_ff     <= mat_rdata;
               state_ff <= M_RD3;
            end
            M_RD3: begin
               z_ff     <= mat_rdata;
               neg_ff   <= x_ff[ELEM_W-1] ^ y_ff[ELEM_W-1] ^ mat_rdata[ELEM_W-1];
               state_ff <= M_W1;
            end
            M_W1: begin
               if (mul_done) begin
                  state_ff <= M_W2;
               end
            end
            M_W2: begin
               if (mul_done) begin
                  if (t_ff == 3'd5) begin
                     acc_ff <= '0;
                     t_ff   <= '0;
                     k_ff   <= k_ff + 4'd1;
                     state_ff <= (k_ff == 4'd15) ? D_RD : M_RD0;
                  end else begin
                     acc_ff   <= sum;
                     t_ff     <= t_ff + 3'd1;
                     state_ff <= M_RD0;
                  end
               end
            end
            D_RD: state_ff <= D_CAP;
            D_CAP: begin
               neg_ff   <= mat_rdata[ELEM_W-1] ^ cof_rdata[WIDE_W-1];
               state_ff <= D_W;
            end
            D_W: begin
               if (mul_done) begin
                  acc_ff <= det_sum;
                  if (k_ff == 4'd3) begin
                     state_ff <= D_FIN;
                  end else begin
                     k_ff     <= k_ff + 4'd1;
                     state_ff <= D_RD;
                  end
               end
            end
            D_FIN: begin
               sing_ff    <= sing_now;
               det_neg_ff <= acc_ff[WIDE_W-1];
               k_ff       <= '0;
               state_ff   <= sing_now ? E_RD : V_W;
            end
            V_W: begin
               if (div_done) begin
                  recip_ff <= div_q;
                  state_ff <= E_RD;
               end
            end
            E_RD: state_ff <= E_CAP;
            E_CAP: begin
               if (sing_ff) begin
                  res_val_ff <= (k_ff[3:2] == k_ff[1:0]) ? ELEM_W'(1 << FRAC_BITS) : '0;
                  res_sat_ff <= 1'b0;
                  state_ff   <= E_OUT;
               end else begin
                  neg_ff   <= cof_rdata[WIDE_W-1] ^ det_neg_ff;
                  state_ff <= E_W;
               end
            end
            E_W: begin
               if (mul_done) begin
                  if (neg_ff) begin
                     if (mul_res > 63'h8000_0000) begin
                        res_val_ff <= 32'h8000_0000;
                        res_sat_ff <= 1'b1;
                     end else begin
                        res_val_ff <= -$signed(mul_res[ELEM_W-1:0]);
                        res_sat_ff <= 1'b0;
                     end
                  end else begin
                     if (mul_res > 63'h7FFF_FFFF) begin
                        res_val_ff <= 32'h7FFF_FFFF;
                        res_sat_ff <= 1'b1;
                     end else begin
                        res_val_ff <= mul_res[ELEM_W-1:0];
                        res_sat_ff <= 1'b0;
                     end
                  end
                  state_ff <= E_OUT;
               end
            end
            E_OUT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= k_ff;
                  rsp_value_ff <= res_val_ff;
                  rsp_sing_ff  <= sing_ff;
                  rsp_sat_ff   <= res_sat_ff;
                  rsp_last_ff  <= (k_ff == 4'd15);
                  k_ff         <= k_ff + 4'd1;
                  state_ff     <= (k_ff == 4'd15) ? S_IDLE : E_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_index = rsp_index_ff;
   assign rsp_bus.out_value = rsp_value_ff;
   assign rsp_bus.singular  = rsp_sing_ff;
   assign rsp_bus.saturated = rsp_sat_ff;
   assign rsp_bus.last      = rsp_last_ff;

endmodule

// ----- tb/matrix_inverse_4x4_checker.sv -----
`timescale 1ns / 1ps

module matrix_inverse_4x4_checker import mi4_pkg::*; (
   input  logic clock,
   input  logic reset,
   mi4_req_if   req_bus,
   mi4_rsp_if   rsp_bus,
   mi4_csr_if   csr_bus,
   output int   fail_count,
   output int   results_waiting,
   output int   results_seen,
   output int   singular_seen,
   output int   saturated_seen
);

   localparam longint WIDE_MAX = longint'(SMAX);

   typedef struct packed {
      logic [IDX_W-1:0]         index;
      logic signed [ELEM_W-1:0] value;
      logic                     singular;
      logic                     saturated;
      logic                     last;
   } inverse_elem_type;

   inverse_elem_type inverse_queue[$];
   longint           elements[DEPTH];
   longint           cofactors[DEPTH];
   logic [THR_W-1:0] threshold;
   int               mismatches;

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] wide_mul_shift(logic [63:0] a, logic [63:0] b,
                                                  int unsigned s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> s;
      if (p > {64'd0, SMAX}) begin
         return SMAX;
      end
      return p[63:0];
   endfunction

   function automatic longint fixed_mul(longint x, longint y);
      logic [63:0] m;
      m = wide_mul_shift(magnitude(x), magnitude(y), FRAC_BITS);
      return ((x < 0) != (y < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clipped_sum(longint a, longint b);
      if (b > 0 && a > WIDE_MAX - b) begin
         return WIDE_MAX;
      end
      if (b < 0 && a < -WIDE_MAX - b) begin
         return -WIDE_MAX;
      end
      return a + b;
   endfunction

   function automatic longint triple_product(longint x, longint y, longint z);
      return fixed_mul(fixed_mul(x, y), z);
   endfunction

   function automatic longint minor_det(int skip_r, int skip_c);
      int     r[3];
      int     c[3];
      int     nr;
      int     nc;
      longint m[3][3];
      longint acc;
      nr  = 0;
      nc  = 0;
      acc = 0;
      for (int i = 0; i < 4; i++) begin
         if (i != skip_r && nr < 3) begin
            r[nr] = i;
            nr++;
         end
         if (i != skip_c && nc < 3) begin
            c[nc] = i;
            nc++;
         end
      end
      for (int i = 0; i < 9; i++) begin
         m[i / 3][i % 3] = elements[c[i % 3] * 4 + r[i / 3]];
      end
      acc = clipped_sum(acc, triple_product(m[0][0], m[1][1], m[2][2]));
      acc = clipped_sum(acc, triple_product(m[0][1], m[1][2], m[2][0]));
      acc = clipped_sum(acc, triple_product(m[0][2], m[1][0], m[2][1]));
      acc = clipped_sum(acc, -triple_product(m[0][2], m[1][1], m[2][0]));
      acc = clipped_sum(acc, -triple_product(m[0][0], m[1][2], m[2][1]));
      acc = clipped_sum(acc, -triple_product(m[0][1], m[1][0], m[2][2]));
      return acc;
   endfunction

   task automatic predict_inverse();
      longint           det;
      logic [63:0]      det_mag;
      logic [63:0]      recip;
      logic [63:0]      m;
      longint           v;
      logic             is_singular;
      logic             clip;
      logic             neg;
      inverse_elem_type e;
      det = 0;
      for (int k = 0; k < 16; k++) begin
         v = minor_det(k >> 2, k & 3);
         cofactors[k] = (((k >> 2) + (k & 3)) & 1) ? -v : v;
      end
      for (int k = 0; k < 4; k++) begin
         det = clipped_sum(det, fixed_mul(elements[k], cofactors[4 * k]));
      end
      det_mag     = magnitude(det);
      is_singular = (det_mag == 0) || (det_mag < {33'd0, threshold});
      recip       = is_singular ? 64'd0 : (64'd1 << 63) / det_mag;
      for (int k = 0; k < 16; k++) begin
         clip = 1'b0;
         if (is_singular) begin
            v = (k % 5 == 0) ? (longint'(1) << FRAC_BITS) : 0;
         end else begin
            m   = wide_mul_shift(magnitude(cofactors[k]), recip, 63 - FRAC_BITS);
            neg = (cofactors[k] < 0) != (det < 0);
            if (neg) begin
               if (m > (64'd1 << 31)) begin
                  m    = 64'd1 << 31;
                  clip = 1'b1;
               end
               v = -longint'(m);
            end else begin
               if (m > 64'h7FFF_FFFF) begin
                  m    = 64'h7FFF_FFFF;
                  clip = 1'b1;
               end
               v = longint'(m);
            end
         end
         e.index     = k[IDX_W-1:0];
         e.value     = v[ELEM_W-1:0];
         e.singular  = is_singular;
         e.saturated = clip;
         e.last      = (k == 15);
         inverse_queue.push_back(e);
      end
   endtask

   assign results_waiting = inverse_queue.size();

   always @(posedge clock) begin
      inverse_elem_type got;
      inverse_elem_type want;
      if (reset) begin
         threshold      = THR_RESET;
         fail_count     = 0;
         results_seen   = 0;
         singular_seen  = 0;
         saturated_seen = 0;
         mismatches     = 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            threshold = csr_bus.det_threshold;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.index     = rsp_bus.out_index;
            got.value     = rsp_bus.out_value;
            got.singular  = rsp_bus.singular;
            got.saturated = rsp_bus.saturated;
            got.last      = rsp_bus.last;
            results_seen++;
            if (got.singular) begin
               singular_seen++;
            end
            if (got.saturated) begin
               saturated_seen++;
            end
            if (inverse_queue.size() == 0) begin
               fail_count++;
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected result transaction: index %0d value %h",
                           got.index, got.value);
               end
            end else begin
               want = inverse_queue.pop_front();
               if (got !== want) begin
                  fail_count++;
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch: expected idx %0d val %h sing %b sat %b last %b",
                              want.index, want.value, want.singular, want.saturated,
                              want.last);
                     $display("          actual   idx %0d val %h sing %b sat %b last %b",
                              got.index, got.value, got.singular, got.saturated, got.last);
                  end
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            elements[req_bus.element_index] = longint'(req_bus.element_value);
            if (req_bus.element_index == 4'd15) begin
               predict_inverse();
            end
         end
      end
   end

endmodule

// ----- tb/matrix_inverse_4x4_unit_test.sv -----
`timescale 1ns / 1ps

module matrix_inverse_4x4_unit_test;
   import mi4_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count;
   int   results_waiting;
   int   results_seen;
   int   singular_seen;
   int   saturated_seen;
   int   inversions;
   int   idle_cycles;
   bit   calm;

   mi4_req_if req_bus ();
   mi4_rsp_if rsp_bus ();
   mi4_csr_if csr_bus ();

   matrix_inverse_4x4_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   matrix_inverse_4x4_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .rsp_bus         (rsp_bus),
      .csr_bus         (csr_bus),
      .fail_count      (fail_count),
      .results_waiting (results_waiting),
      .results_seen    (results_seen),
      .singular_seen   (singular_seen),
      .saturated_seen  (saturated_seen)
   );

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic logic [31:0] pick_element(int idx);
      logic [31:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
         2: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7FFF_FFFF;
               1: v = 32'h8000_0000;
               2: v = 32'hFFFF_FFFF;
               default: v = 32'h0000_0001;
            endcase
         end
         3: v = 32'd0;
         default: begin
            v = 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
            if (idx % 5 == 0) begin
               v = v + 32'h0008_0000;
            end
         end
      endcase
      return v;
   endfunction

   task automatic send_element(logic [3:0] idx, logic [31:0] val);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.element_index <= idx;
      req_bus.element_value <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (idx == 4'd15) begin
         inversions++;
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_threshold(logic [THR_W-1:0] thr);
      csr_bus.valid         <= 1'b1;
      csr_bus.det_threshold <= thr;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_full_matrix();
      int order[15];
      int j;
      int t;
      for (int i = 0; i < 15; i++) begin
         order[i] = i;
      end
      for (int i = 14; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < 15; i++) begin
         send_element(order[i][3:0], pick_element(order[i]));
      end
      send_element(4'd15, pick_element(15));
   endtask

   task automatic random_phase(int item_budget);
      int sent;
      int n;
      int idx;
      sent = 0;
      while (sent < item_budget) begin
         calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) begin
            load_full_matrix();
            sent += 16;
         end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
               idx = $urandom_range(0, 14);
               send_element(idx[3:0], pick_element(idx));
            end
            send_element(4'd15, pick_element(15));
            sent += n + 1;
         end
      end
      drain_results();
   endtask

   initial begin
      forever begin
         int gap;
         gap = draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding", results_waiting);
         $display("** matrix_inverse_4x4_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.element_index <= '0;
      req_bus.element_value <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.det_threshold <= '0;
      inversions            = 0;
      calm                  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity matrix, then extreme values in the corner and a zero determinant.
      for (int i = 0; i < 16; i++) begin
         send_element(i[3:0], (i % 5 == 0) ? 32'h0001_0000 : 32'd0);
      end
      send_element(4'd0, 32'h7FFF_FFFF);
      send_element(4'd15, 32'h0001_0000);
      send_element(4'd0, 32'h8000_0000);
      send_element(4'd15, 32'hFFFF_0000);
      send_element(4'd0, 32'd0);
      send_element(4'd15, 32'h0001_0000);
      drain_results();

      // A tiny determinant with no threshold gives clipped results; a zero one is still singular.
      set_threshold('0);
      send_element(4'd0, 32'd1);
      send_element(4'd15, 32'h0001_0000);
      send_element(4'd0, 32'd0);
      send_element(4'd15, 32'h0001_0000);
      drain_results();

      random_phase(20);
      set_threshold({THR_W{1'b1}});
      random_phase(15);
      set_threshold(THR_RESET);
      random_phase(20);
      set_threshold(THR_W'($urandom_range(0, 32'h0010_0000)));
      random_phase(15);

      $display("Ran %0d inversions; %0d results checked, %0d singular, %0d clipped.",
               inversions, results_seen, singular_seen, saturated_seen);
      if (fail_count == 0) begin
         $display("** matrix_inverse_4x4_unit: PASSED **");
      end else begin
         $display("** matrix_inverse_4x4_unit: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/mi4_pkg.sv
sv/mi4_if.sv
sv/mi4_ram.sv
sv/mi4_mul.sv
sv/mi4_div.sv
sv/matrix_inverse_4x4_unit.sv
tb/matrix_inverse_4x4_checker.sv
tb/matrix_inverse_4x4_unit_test.sv
